@@ hw/rtl/kmda_pkg.sv @@
// shared types, constants and helpers for the key matrix debounce and auto-repeat unit
package kmda_pkg;

	localparam int ROWS = 3;
	localparam int COLS = 3;
	localparam int NKEYS = ROWS * COLS;
	// width of the down-bit field; keys at or above it always read as up
	localparam int DOWN_W = 9;
	localparam int KEY_W = 4;
	localparam int KIND_W = 2;
	localparam int CNT_W = 16;
	localparam int TIME_W = 64;
	localparam int DELAY_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// event kinds
	localparam logic [KIND_W-1:0] EV_PRESS = 2'd0;
	localparam logic [KIND_W-1:0] EV_FIRST_REPEAT = 2'd1;
	localparam logic [KIND_W-1:0] EV_REPEAT = 2'd2;
	localparam logic [KIND_W-1:0] EV_RELEASE = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REPEAT_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 2'd2;

	// register reset values
	localparam logic [CNT_W-1:0] DEBOUNCE_LIMIT_RST = 16'd5;
	localparam logic [DELAY_W-1:0] FIRST_REPEAT_DELAY_RST = 32'd500000;
	localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 32'd33000;

	typedef struct packed {
		logic [CNT_W-1:0] debounce_limit;
		logic [DELAY_W-1:0] first_repeat_delay_us;
		logic [DELAY_W-1:0] repeat_delay_us;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic [KIND_W-1:0] kind;
	} lane_ev_t;

	// key index of the key visited at a given column-major position
	function automatic int pos_key(input int pos);
		return (pos % ROWS) * COLS + pos / ROWS;
	endfunction

endpackage

@@ hw/rtl/kmda_lane.sv @@
// per-key lane: debounce count, press and repeat flags, start time of the press or last repeat
module kmda_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 step,
	input  logic                                 down,
	input  logic [kmda_pkg::TIME_W-1:0]          now_us,
	input  kmda_pkg::cfg_t                       cfg,
	output kmda_pkg::lane_ev_t                   ev
);
	import kmda_pkg::*;

	logic [CNT_W-1:0] cnt_q, cnt_n, cnt_inc;
	logic pressed_q, pressed_n;
	logic repeating_q, repeating_n;
	logic [TIME_W-1:0] start_q, start_n;
	logic [TIME_W-1:0] elapsed;

	assign elapsed = now_us - start_q;
	assign cnt_inc = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + CNT_W'(1);

	// next state and event for this scan
	always_comb begin
		cnt_n = cnt_q;
		pressed_n = pressed_q;
		repeating_n = repeating_q;
		start_n = start_q;
		ev.valid = 1'b0;
		ev.kind = EV_PRESS;
		if (down) begin
			cnt_n = cnt_inc;
			if (repeating_q) begin
				if (elapsed > TIME_W'(cfg.repeat_delay_us)) begin
					start_n = now_us;
					ev.valid = 1'b1;
					ev.kind = EV_REPEAT;
				end
			end else if (pressed_q) begin
				if (elapsed > TIME_W'(cfg.first_repeat_delay_us)) begin
					repeating_n = 1'b1;
					start_n = now_us;
					ev.valid = 1'b1;
					ev.kind = EV_FIRST_REPEAT;
				end
			end else if (cnt_inc > cfg.debounce_limit) begin
				cnt_n = '0;
				pressed_n = 1'b1;
				start_n = now_us;
				ev.valid = 1'b1;
				ev.kind = EV_PRESS;
			end
		end else if (pressed_q) begin
			cnt_n = '0;
			pressed_n = 1'b0;
			repeating_n = 1'b0;
			start_n = '0;
			ev.valid = 1'b1;
			ev.kind = EV_RELEASE;
		end
	end

	// key state, updated once per accepted scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pressed_q <= 1'b0;
			repeating_q <= 1'b0;
			start_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_n;
			pressed_q <= pressed_n;
			repeating_q <= repeating_n;
			start_q <= start_n;
		end
	end

endmodule

@@ hw/rtl/kmda_merge.sv @@
// merge stage: holds a scan's lane events, sends one per unstalled cycle in column-major order
module kmda_merge (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      load,
	input  kmda_pkg::lane_ev_t [kmda_pkg::NKEYS-1:0]  lane_ev,
	output logic                                      busy,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic [kmda_pkg::KEY_W-1:0]                key_index,
	output logic [kmda_pkg::KIND_W-1:0]               event_kind,
	output logic                                      last_of_scan
);
	import kmda_pkg::*;

	// pending events indexed by visit position
	logic [NKEYS-1:0] pend_q;
	logic [KIND_W-1:0] kind_q [NKEYS];
	logic [NKEYS-1:0] sel, pend_rest;
	logic [KEY_W-1:0] sel_key;
	logic [KIND_W-1:0] sel_kind;
	logic pick;
	logic out_valid_q;
	logic [KEY_W-1:0] key_q;
	logic [KIND_W-1:0] ev_kind_q;
	logic last_q;

	assign busy = |pend_q;
	assign pick = busy && (!out_valid_q || !out_stall);

	// first pending position and what is left behind it
	assign sel = pend_q & (~pend_q + NKEYS'(1));
	assign pend_rest = pend_q & ~sel;

	always_comb begin
		sel_key = '0;
		sel_kind = '0;
		for (int p = 0; p < NKEYS; p++) begin
			if (sel[p]) begin
				sel_key = sel_key | KEY_W'(pos_key(p));
				sel_kind = sel_kind | kind_q[p];
			end
		end
	end

	// pending mask: loaded on a scan request, cleared one event at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			for (int p = 0; p < NKEYS; p++) begin
				pend_q[p] <= lane_ev[pos_key(p)].valid;
			end
		end else if (pick) begin
			pend_q <= pend_rest;
		end
	end

	// event kinds of the loaded scan
	always_ff @(posedge clk) begin
		if (load) begin
			for (int p = 0; p < NKEYS; p++) begin
				kind_q[p] <= lane_ev[pos_key(p)].kind;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pick) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pick) begin
			key_q <= sel_key;
			ev_kind_q <= sel_kind;
			last_q <= ~|pend_rest;
		end
	end

	assign out_valid = out_valid_q;
	assign key_index = key_q;
	assign event_kind = ev_kind_q;
	assign last_of_scan = last_q;

endmodule

@@ hw/rtl/key_matrix_debounce_autorepeat_unit.sv @@
// top level: register file, per-key lanes and the event merge stage
// Latency: the first event of a scan passes through the pending mask and then the output register.
// Throughput: one event per cycle while out_stall is low; the input is stalled while any event of
// a scan is pending, and a scan that causes no event does not stall the input.
// This is set by the single output register draining the pending events in order.
// Reset (arst_n low, asynchronous): all key state clears, registers return to 5/500000/33000.
module key_matrix_debounce_autorepeat_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [kmda_pkg::DOWN_W-1:0]         key_down_bits,
	input  logic [kmda_pkg::TIME_W-1:0]         now_us,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [kmda_pkg::KEY_W-1:0]          key_index,
	output logic [kmda_pkg::KIND_W-1:0]         event_kind,
	output logic                                last_of_scan,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kmda_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kmda_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import kmda_pkg::*;

	cfg_t cfg_q;
	lane_ev_t [NKEYS-1:0] lane_ev;
	logic accept;
	logic busy;

	assign cfg_ready = 1'b1;
	assign accept = in_valid && !in_stall;
	assign in_stall = busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_limit <= DEBOUNCE_LIMIT_RST;
			cfg_q.first_repeat_delay_us <= FIRST_REPEAT_DELAY_RST;
			cfg_q.repeat_delay_us <= REPEAT_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEBOUNCE_LIMIT: begin
					cfg_q.debounce_limit <= cfg_data[CNT_W-1:0];
				end
				CFG_FIRST_REPEAT_DELAY: begin
					cfg_q.first_repeat_delay_us <= cfg_data[DELAY_W-1:0];
				end
				CFG_REPEAT_DELAY: begin
					cfg_q.repeat_delay_us <= cfg_data[DELAY_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// one lane per key
	for (genvar k = 0; k < NKEYS; k++) begin : g_lane
		logic down;
		if (k < DOWN_W) begin : g_in
			assign down = key_down_bits[k];
		end else begin : g_up
			assign down = 1'b0;
		end
		kmda_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (accept),
			.down   (down),
			.now_us (now_us),
			.cfg    (cfg_q),
			.ev     (lane_ev[k])
		);
	end

	kmda_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.lane_ev      (lane_ev),
		.busy         (busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.key_index    (key_index),
		.event_kind   (event_kind),
		.last_of_scan (last_of_scan)
	);

`ifndef ASSERT_OFF
	// an event that is not the last of its scan leaves more of that scan pending
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_scan |-> in_stall)
		else $error("non-final event shown with nothing pending");

	// pending events move to the output whenever it is free
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> out_valid)
		else $error("pending event not moved to output");

	// pending work only appears after a scan request
	a_pend_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("pending events without a scan request");
`endif

endmodule
